>>> sv/assert_macros.svh
// Concurrent assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tdp_pkg.sv
package tdp_pkg;

    localparam int NUMBER_WIDTH = 32;
    // Trial divisors stay at or below sqrt(2^(NUMBER_WIDTH-1)) + 8.
    localparam int DIV_W        = NUMBER_WIDTH / 2 + 1;
    localparam int SQ_W         = NUMBER_WIDTH + 1;
    localparam int CNT_W        = $clog2(NUMBER_WIDTH);

    localparam int WHEEL_START  = 5;
    localparam int WHEEL_STEP   = 6;
    localparam int PAIR_GAP     = 2;
    localparam int SMALL_PRIME  = 3;

    localparam logic [NUMBER_WIDTH-1:0] NUM_ONE   = NUMBER_WIDTH'(1);
    localparam logic [NUMBER_WIDTH-1:0] NUM_THREE = NUMBER_WIDTH'(SMALL_PRIME);
    localparam logic [DIV_W-1:0]        DIV_THREE = DIV_W'(SMALL_PRIME);
    localparam logic [DIV_W-1:0]        DIV_START = DIV_W'(WHEEL_START);
    localparam logic [DIV_W-1:0]        DIV_GAP   = DIV_W'(PAIR_GAP);
    localparam logic [DIV_W-1:0]        DIV_STEP  = DIV_W'(WHEEL_STEP);
    localparam logic [SQ_W-1:0]         SQ_START  = SQ_W'(WHEEL_START * WHEEL_START);
    localparam logic [SQ_W-1:0]         SQ_STEP   = SQ_W'(WHEEL_STEP * WHEEL_STEP);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_rsp_t;

endpackage

>>> sv/trial_division_prime_test_top.sv
// Trial-division primality test on the 6k +/- 1 wheel.
// Input channel: in_valid / in_stall with the signed field number. A transfer
// takes place on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with is_prime, one result per number.
// The block holds one number at a time: in_stall is high from the transfer
// until its result has moved into the output register.
// Negatives, 0..3 and even numbers are settled without the divider. Others
// pay one remainder by 3 on the bit-serial divider, then per wheel step one
// compare state plus two remainders. The step count is about sqrt(number) / 6,
// so a large prime near 2^31 runs the longest search, whose length the shared
// one-bit-per-cycle divider sets.
// The output register parts the two sides: while a result waits under
// out_stall the next number is already accepted and searched, and only its
// own hand-off waits for the register to empty.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// out_valid; a number in progress is dropped.
module trial_division_prime_test_top
    import tdp_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [NUMBER_WIDTH-1:0] number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_prime
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECIDE = 7'b0000010,
        ST_WAIT3  = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_WAITA  = 7'b0010000,
        ST_WAITB  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] held_reg, held_next;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    result_reg, result_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_prime_reg, out_prime_next;
    div_req_t                req;
    div_rsp_t                rsp;

    tdp_div_serial u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dividend (held_reg),
        .rsp      (rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        req.start      = 1'b0;
        req.divisor    = div_reg;

        // Drop the result once it is transferred.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    held_next  = unsigned'(number);
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (held_reg[NUMBER_WIDTH-1] || held_reg <= NUM_ONE)
                begin
                    result_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else if (held_reg <= NUM_THREE)
                begin
                    result_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (!held_reg[0])
                begin
                    result_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    req.start   = 1'b1;
                    req.divisor = DIV_THREE;
                    state_next  = ST_WAIT3;
                end
            end
            ST_WAIT3:
            begin
                if (rsp.done)
                begin
                    if (rsp.rem_zero)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        div_next   = DIV_START;
                        sq_next    = SQ_START;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // Stop once i*i exceeds the number.
                if (sq_reg > SQ_W'(held_reg))
                begin
                    result_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    req.start   = 1'b1;
                    req.divisor = div_reg;
                    state_next  = ST_WAITA;
                end
            end
            ST_WAITA:
            begin
                if (rsp.done)
                begin
                    if (rsp.rem_zero)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        req.start   = 1'b1;
                        req.divisor = div_reg + DIV_GAP;
                        state_next  = ST_WAITB;
                    end
                end
            end
            ST_WAITB:
            begin
                if (rsp.done)
                begin
                    if (rsp.rem_zero)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        // (i+6)^2 = i^2 + 12i + 36
                        div_next   = div_reg + DIV_STEP;
                        sq_next    = sq_reg + SQ_W'({div_reg, 3'b000})
                                   + SQ_W'({div_reg, 2'b00}) + SQ_STEP;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        div_reg       <= div_next;
        sq_reg        <= sq_next;
        result_reg    <= result_next;
        out_prime_reg <= out_prime_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = out_prime_reg;

endmodule

>>> sv/tdp_div_serial.sv
module tdp_div_serial
    import tdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_req_t                req,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    output div_rsp_t                rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        dsr_reg, dsr_next;
    logic [DIV_W:0]          trial;
    logic [DIV_W:0]          diff;
    logic                    fits;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        trial      = {rem_reg, shift_reg[NUMBER_WIDTH-1]};
        diff       = trial - {1'b0, dsr_reg};
        fits       = (trial >= {1'b0, dsr_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            dsr_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
            rem_next   = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUMBER_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

>>> sv/tdp_checker.sv
`include "assert_macros.svh"

module tdp_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
);

    // A held result stays offered.
    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

    // One number in flight: the input side closes right after a transfer.
    `ASSERT_CLK(a_busy_after_in, in_valid && !in_stall |=> in_stall, "input open while busy")

    // No result can appear on the edge right after an input transfer.
    `ASSERT_CLK(a_no_instant_out, in_valid && !in_stall |=> !$rose(out_valid),
        "result without search")

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "output valid in reset")

endmodule

bind trial_division_prime_test_top tdp_checker u_tdp_checker (.*);

>>> tb/tb_trial_division_prime_test_top.sv
module tb_trial_division_prime_test_top;
    import tdp_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int          RANDOM_ITEMS = 78;
    localparam int          HOLD_AT      = 30;
    localparam int          HOLD_CYCLES  = 400;

    typedef struct {
        logic [NUMBER_WIDTH-1:0] value;
        bit                      verdict;
    } verdict_t;

    logic                           clk;
    logic                           rst_n = 1'b1;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic signed [NUMBER_WIDTH-1:0] number = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           is_prime;

    logic [NUMBER_WIDTH-1:0] pending_numbers[$];
    verdict_t                expected_verdicts[$];
    verdict_t                accepted_item;
    verdict_t                oldest_verdict;
    int                      mismatch_count = 0;
    int                      results_checked = 0;
    int unsigned             tx_wait = 0;
    int unsigned             rx_wait = 0;
    bit                      tx_quiet = 1'b0;
    bit                      rx_quiet = 1'b0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;
    int unsigned             idle_cycles = 0;

    trial_division_prime_test_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    // Trial division on the 6k +/- 1 wheel, square bound taken at 64 bits.
    function automatic bit prime_verdict(input logic [NUMBER_WIDTH-1:0] n);
        longint unsigned v;
        longint unsigned d;
        v = n;
        if (n[NUMBER_WIDTH-1])
            return 1'b0;
        if (v <= 1)
            return 1'b0;
        if (v <= SMALL_PRIME)
            return 1'b1;
        if (v % 2 == 0 || v % SMALL_PRIME == 0)
            return 1'b0;
        for (d = WHEEL_START; d * d <= v; d += WHEEL_STEP)
        begin
            if (v % d == 0 || v % (d + PAIR_GAP) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: offer queued numbers, hold a stalled transfer unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            number   <= '0;
            tx_wait  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_item.value   = number;
                accepted_item.verdict = prime_verdict(number);
                expected_verdicts     = {expected_verdicts, accepted_item};
            end
            if (!(in_valid && in_stall))
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_numbers.size() > 0)
                begin
                    number   <= pending_numbers.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        tx_quiet = !tx_quiet;
                    tx_wait = draw_wait(tx_quiet);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("result is_prime=%b with none expected",
                                              is_prime));
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (is_prime !== oldest_verdict.verdict)
                        report_mismatch($sformatf("number %0d: is_prime=%b, want %b",
                                                  $signed(oldest_verdict.value), is_prime,
                                                  oldest_verdict.verdict));
                end
                results_checked <= results_checked + 1;
                if ($urandom_range(0, 15) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = draw_wait(rx_quiet);
            end
            else if (out_valid && rx_wait > 0)
                rx_wait--;
            out_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // Long hold-off on the output so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_checked == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [31:0] directed_numbers [] = '{
            32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1, 32'd2, 32'd3,
            32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd35, 32'd49, 32'd97,
            32'd121, 32'd143, 32'd289, 32'd323, 32'd65537,
            32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF
        };
        int unsigned factors [] = '{2, 3, 5, 7, 11, 13, 17, 19};
        int unsigned pick;
        int unsigned k;
        int unsigned a;
        int unsigned b;
        logic [31:0] candidate;

        // Assert reset with a real falling edge so the asynchronous reset fires.
        rst_n <= 1'b0;

        foreach (directed_numbers[j])
            pending_numbers = {pending_numbers, directed_numbers[j]};

        for (int j = 0; j < RANDOM_ITEMS; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                candidate = $urandom_range(0, 2000);
            else if (pick < 60)
            begin
                // Products of two odd numbers can run the wheel before a factor hits.
                a = 2 * $urandom_range(2, 200) + 1;
                b = 2 * $urandom_range(2, 200) + 1;
                candidate = a * b;
            end
            else if (pick < 70)
                candidate = $urandom_range(0, 1 << 20);
            else if (pick < 88)
            begin
                // Wide values, kept fast by a small factor.
                k = factors[$urandom_range(0, factors.size() - 1)];
                candidate = $urandom_range(1, 32'h7FFF_FFFF / k) * k;
            end
            else
                candidate = $urandom | 32'h8000_0000;
            pending_numbers = {pending_numbers, candidate};
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_numbers.size() == 0 && !in_valid);
        wait (expected_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/tdp_pkg.sv
sv/tdp_div_serial.sv
sv/trial_division_prime_test_top.sv
sv/tdp_checker.sv
tb/tb_trial_division_prime_test_top.sv
